// File: hw/rtl/two_stage_divider_search_assert.svh
// assertion macros shared by the two_stage_divider_search modules
`ifndef TWO_STAGE_DIVIDER_SEARCH_ASSERT_SVH
`define TWO_STAGE_DIVIDER_SEARCH_ASSERT_SVH

// same-cycle implication, held off during reset
`define TSDS_ASSERT_IMPL(label, ck, rs, cond, prop) \
  label: assert property (@(posedge ck) disable iff (rs) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define TSDS_ASSERT_NEXT(label, ck, rs, cond, prop) \
  label: assert property (@(posedge ck) disable iff (rs) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/tsds_pkg.sv
// shared constants and controller/datapath interface types
`default_nettype none

package tsds_pkg;

  localparam int RATIO_W       = 32;
  localparam int DIV_W         = 16;
  localparam int DIV_CNT_W     = $clog2(RATIO_W);
  localparam int DIVIDER_LIMIT = 65000;
  localparam int SEARCH_FLOOR  = 1000;
  localparam int LOW_FIXED     = 2;

  localparam logic [RATIO_W-1:0]   TIMER_CLOCK_RESET = 32'd1193182;
  localparam logic [RATIO_W-1:0]   LIMIT_RATIO       = RATIO_W'(DIVIDER_LIMIT);
  localparam logic [DIV_W-1:0]     LIMIT_DIV         = DIV_W'(DIVIDER_LIMIT);
  localparam logic [DIV_W-1:0]     FLOOR_DIV         = DIV_W'(SEARCH_FLOOR);
  localparam logic [DIV_W-1:0]     LAST_CAND         = DIV_W'(SEARCH_FLOOR + 1);
  localparam logic [DIV_CNT_W-1:0] WIDE_LAST         = DIV_CNT_W'(RATIO_W - 1);
  localparam logic [DIV_CNT_W-1:0] NARROW_LAST       = DIV_CNT_W'(RATIO_W / 2 - 1);

  typedef struct packed {
    logic start_ratio;
    logic div_step;
    logic search_init;
    logic search_next;
    logic eval;
    logic set_err;
    logic set_direct;
    logic set_search;
    logic load_out;
  } tsds_cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic div_last;
    logic big_ratio;
    logic range_empty;
    logic cand_last;
  } tsds_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/two_stage_divider_search.sv
// Two-stage divider search: splits timer_clock / requested_freq into two 16-bit dividers.
// Input channel: in_valid/in_ready with requested_freq; one transfer per request.
// Output channel: out_valid/out_ready with high_divider, low_divider, status (1 = error).
// Config: cfg_we/cfg_wdata write timer_clock; write it only while no request is in flight.
// The ratio comes from a shift-subtract divider, which a zero rate skips; a ratio up to
// the divider limit goes straight to the result once the division ends.
// Larger ratios run a candidate search: each candidate costs a 2-bit-per-cycle
// remainder on the shared divider plus one compare, and the search tries
// start - 1000 candidates, from start down to 1001.
// One request is worked on at a time; in_ready is high only while the engine is idle.
// A finished result sits in an output register, so the next request is taken while
// the receiver stalls; that request's result then waits until the register is free.
// Reset (rst, synchronous) empties the engine and output and sets timer_clock to 1193182.
`default_nettype none

module two_stage_divider_search (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tsds_pkg::RATIO_W-1:0]  cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tsds_pkg::RATIO_W-1:0]  requested_freq,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tsds_pkg::DIV_W-1:0]    high_divider,
  output logic      [tsds_pkg::DIV_W-1:0]    low_divider,
  output logic                               status
);

  tsds_pkg::tsds_cmd_t  cmd;
  tsds_pkg::tsds_stat_t stat;

  tsds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsds_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .requested_freq (requested_freq),
    .cmd            (cmd),
    .stat           (stat),
    .high_divider   (high_divider),
    .low_divider    (low_divider),
    .status         (status)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tsds_datapath.sv
// datapath: timer clock register, iterative divider, search registers, result
`default_nettype none
`include "two_stage_divider_search_assert.svh"

module tsds_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tsds_pkg::RATIO_W-1:0]   cfg_wdata,
  input  wire logic [tsds_pkg::RATIO_W-1:0]   requested_freq,
  input  wire tsds_pkg::tsds_cmd_t            cmd,
  output tsds_pkg::tsds_stat_t                stat,
  output logic      [tsds_pkg::DIV_W-1:0]     high_divider,
  output logic      [tsds_pkg::DIV_W-1:0]     low_divider,
  output logic                                status
);

  logic [tsds_pkg::RATIO_W-1:0]   timer_clock;
  logic [tsds_pkg::RATIO_W-1:0]   div_rem;
  logic [tsds_pkg::RATIO_W-1:0]   div_quo;
  logic [tsds_pkg::RATIO_W-1:0]   div_den;
  logic [tsds_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                           div_wide;
  logic [tsds_pkg::RATIO_W-1:0]   ratio;
  logic [tsds_pkg::DIV_W-1:0]     cand;
  logic [tsds_pkg::DIV_W-1:0]     best_div;
  logic [tsds_pkg::DIV_W-1:0]     best_rem;
  logic [tsds_pkg::RATIO_W-1:0]   best_quo;
  logic [tsds_pkg::DIV_W-1:0]     res_hi;
  logic [tsds_pkg::DIV_W-1:0]     res_lo;
  logic                           res_st;

  // one restoring step over the full width
  logic [tsds_pkg::RATIO_W:0]     wide_part;
  logic [tsds_pkg::RATIO_W:0]     wide_diff;
  logic                           wide_ge;
  logic [tsds_pkg::RATIO_W-1:0]   wide_rem;

  // two restoring steps on a 16-bit divisor
  logic [tsds_pkg::DIV_W:0]       n1_part;
  logic [tsds_pkg::DIV_W:0]       n1_diff;
  logic                           n1_ge;
  logic [tsds_pkg::DIV_W-1:0]     n1_rem;
  logic [tsds_pkg::DIV_W:0]       n2_part;
  logic [tsds_pkg::DIV_W:0]       n2_diff;
  logic                           n2_ge;
  logic [tsds_pkg::DIV_W-1:0]     n2_rem;

  logic [tsds_pkg::RATIO_W-2:0]   half;
  logic [tsds_pkg::DIV_W-1:0]     start;
  logic [tsds_pkg::DIV_W-1:0]     cand_minus;
  logic                           search_bad;

  always_comb begin
    wide_part = {div_rem, div_quo[tsds_pkg::RATIO_W-1]};
    wide_diff = wide_part - {1'b0, div_den};
    wide_ge   = (wide_part >= {1'b0, div_den});
    wide_rem  = wide_ge ? wide_diff[tsds_pkg::RATIO_W-1:0]
                        : wide_part[tsds_pkg::RATIO_W-1:0];

    n1_part = {div_rem[tsds_pkg::DIV_W-1:0], div_quo[tsds_pkg::RATIO_W-1]};
    n1_diff = n1_part - {1'b0, div_den[tsds_pkg::DIV_W-1:0]};
    n1_ge   = (n1_part >= {1'b0, div_den[tsds_pkg::DIV_W-1:0]});
    n1_rem  = n1_ge ? n1_diff[tsds_pkg::DIV_W-1:0] : n1_part[tsds_pkg::DIV_W-1:0];
    n2_part = {n1_rem, div_quo[tsds_pkg::RATIO_W-2]};
    n2_diff = n2_part - {1'b0, div_den[tsds_pkg::DIV_W-1:0]};
    n2_ge   = (n2_part >= {1'b0, div_den[tsds_pkg::DIV_W-1:0]});
    n2_rem  = n2_ge ? n2_diff[tsds_pkg::DIV_W-1:0] : n2_part[tsds_pkg::DIV_W-1:0];

    half       = div_quo[tsds_pkg::RATIO_W-1:1];
    start      = (half > tsds_pkg::LIMIT_RATIO[tsds_pkg::RATIO_W-2:0])
                 ? tsds_pkg::LIMIT_DIV : half[tsds_pkg::DIV_W-1:0];
    cand_minus = cand - tsds_pkg::DIV_W'(1);
    search_bad = (best_div == '0) || (best_quo == '0)
                 || (best_quo[tsds_pkg::RATIO_W-1:tsds_pkg::DIV_W] != '0);

    stat.freq_zero   = (requested_freq == '0);
    stat.div_last    = div_wide ? (div_cnt == tsds_pkg::WIDE_LAST)
                                : (div_cnt == tsds_pkg::NARROW_LAST);
    stat.big_ratio   = (div_quo > tsds_pkg::LIMIT_RATIO);
    stat.range_empty = (start <= tsds_pkg::FLOOR_DIV);
    stat.cand_last   = (cand == tsds_pkg::LAST_CAND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock <= tsds_pkg::TIMER_CLOCK_RESET;
    end else if (cfg_we) begin
      timer_clock <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_rem      <= '0;
      div_quo      <= '0;
      div_den      <= '0;
      div_cnt      <= '0;
      div_wide     <= 1'b0;
      ratio        <= '0;
      cand         <= '0;
      best_div     <= '0;
      best_rem     <= '1;
      best_quo     <= '0;
      res_hi       <= '0;
      res_lo       <= '0;
      res_st       <= 1'b0;
      high_divider <= '0;
      low_divider  <= '0;
      status       <= 1'b0;
    end else begin
      if (cmd.start_ratio) begin
        div_rem  <= '0;
        div_quo  <= timer_clock;
        div_den  <= requested_freq;
        div_cnt  <= '0;
        div_wide <= 1'b1;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + tsds_pkg::DIV_CNT_W'(1);
        if (div_wide) begin
          div_rem <= wide_rem;
          div_quo <= {div_quo[tsds_pkg::RATIO_W-2:0], wide_ge};
        end else begin
          div_rem <= {{(tsds_pkg::RATIO_W-tsds_pkg::DIV_W){1'b0}}, n2_rem};
          div_quo <= {div_quo[tsds_pkg::RATIO_W-3:0], n1_ge, n2_ge};
        end
      end
      if (cmd.search_init) begin
        ratio    <= div_quo;
        cand     <= start;
        best_rem <= '1;
        best_div <= '0;
        best_quo <= '0;
        div_rem  <= '0;
        div_quo  <= div_quo;
        div_den  <= {{(tsds_pkg::RATIO_W-tsds_pkg::DIV_W){1'b0}}, start};
        div_cnt  <= '0;
        div_wide <= 1'b0;
      end
      // keep the first candidate with a strictly smaller remainder
      if (cmd.eval && (div_rem[tsds_pkg::DIV_W-1:0] < best_rem)) begin
        best_rem <= div_rem[tsds_pkg::DIV_W-1:0];
        best_div <= cand;
        best_quo <= div_quo;
      end
      if (cmd.search_next) begin
        cand     <= cand_minus;
        div_rem  <= '0;
        div_quo  <= ratio;
        div_den  <= {{(tsds_pkg::RATIO_W-tsds_pkg::DIV_W){1'b0}}, cand_minus};
        div_cnt  <= '0;
        div_wide <= 1'b0;
      end
      if (cmd.set_err) begin
        res_hi <= '0;
        res_lo <= '0;
        res_st <= 1'b1;
      end
      if (cmd.set_direct) begin
        ratio <= div_quo;
        if (div_quo[tsds_pkg::DIV_W:1] == '0) begin
          res_hi <= '0;
          res_lo <= '0;
          res_st <= 1'b1;
        end else begin
          res_hi <= div_quo[tsds_pkg::DIV_W:1];
          res_lo <= tsds_pkg::DIV_W'(tsds_pkg::LOW_FIXED);
          res_st <= 1'b0;
        end
      end
      if (cmd.set_search) begin
        res_hi <= search_bad ? '0 : best_div;
        res_lo <= search_bad ? '0 : best_quo[tsds_pkg::DIV_W-1:0];
        res_st <= search_bad;
      end
      if (cmd.load_out) begin
        high_divider <= res_hi;
        low_divider  <= res_lo;
        status       <= res_st;
      end
    end
  end

  `TSDS_ASSERT_IMPL(a_rem_below_cand, clk, rst, cmd.eval, div_rem[tsds_pkg::DIV_W-1:0] < cand)
  `TSDS_ASSERT_IMPL(a_search_on_big_ratio, clk, rst, cmd.search_init, div_quo > tsds_pkg::LIMIT_RATIO)

endmodule

`default_nettype wire

// File: hw/rtl/tsds_ctrl.sv
// controller: sequences the ratio division, the candidate search and the result transfer
`default_nettype none
`include "two_stage_divider_search_assert.svh"

module tsds_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire tsds_pkg::tsds_stat_t stat,
  output tsds_pkg::tsds_cmd_t       cmd
);

  typedef enum logic [2:0] {
    IDLE,
    RATIO,
    CHECK,
    SEARCH,
    EVAL,
    RESOLVE,
    FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          if (stat.freq_zero) begin
            cmd.set_err = 1'b1;
          end else begin
            cmd.start_ratio = 1'b1;
          end
        end
      end
      RATIO:  cmd.div_step = 1'b1;
      CHECK: begin
        if (!stat.big_ratio) begin
          cmd.set_direct = 1'b1;
        end else if (stat.range_empty) begin
          cmd.set_err = 1'b1;
        end else begin
          cmd.search_init = 1'b1;
        end
      end
      SEARCH: cmd.div_step = 1'b1;
      EVAL: begin
        cmd.eval        = 1'b1;
        cmd.search_next = !stat.cand_last;
      end
      RESOLVE: cmd.set_search = 1'b1;
      FINISH:  cmd.load_out = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= stat.freq_zero ? FINISH : RATIO;
          end
        end
        RATIO: begin
          if (stat.div_last) begin
            state <= CHECK;
          end
        end
        CHECK: begin
          state <= (stat.big_ratio && !stat.range_empty) ? SEARCH : FINISH;
        end
        SEARCH: begin
          if (stat.div_last) begin
            state <= EVAL;
          end
        end
        EVAL:    state <= stat.cand_last ? RESOLVE : SEARCH;
        RESOLVE: state <= FINISH;
        FINISH: begin
          if (cmd.load_out) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `TSDS_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.load_out, !out_valid || out_ready)
  `TSDS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready, !in_ready)
  `TSDS_ASSERT_NEXT(a_load_sets_valid, clk, rst, cmd.load_out, out_valid)

endmodule

`default_nettype wire

// File: verif/tb.sv
// testbench for two_stage_divider_search: predicts each divider pair and checks every result
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [15:0] hi_div;
    logic [15:0] lo_div;
    logic        err;
  } divider_pair_t;

  localparam int RAND_PER_CLOCK = 20;
  localparam int DIRECTED_COUNT = 15;
  localparam int CYCLE_LIMIT    = 12_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] requested_freq = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] high_divider;
  logic [15:0] low_divider;
  logic        status;

  logic [31:0]   freq_queue[$];
  divider_pair_t split_queue[$];
  divider_pair_t want_split;
  logic [31:0]   clock_shadow = tsds_pkg::TIMER_CLOCK_RESET;
  int            in_flight = 0;
  int            accepted = 0;
  int            planned = 1;
  int            errors = 0;
  int            cycles = 0;

  two_stage_divider_search dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .requested_freq(requested_freq),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .high_divider  (high_divider),
    .low_divider   (low_divider),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected divider pair for one request at the given timer clock
  function automatic divider_pair_t split_ratio(input logic [31:0] freq,
                                                input logic [31:0] rate);
    logic [31:0]   ratio;
    logic [31:0]   start;
    logic [31:0]   rem;
    logic [31:0]   hi;
    logic [31:0]   lo;
    logic [15:0]   best_rem;
    logic [15:0]   best_div;
    divider_pair_t res;
    res = '{hi_div: 16'd0, lo_div: 16'd0, err: 1'b1};
    if (freq == 32'd0) return res;
    ratio = rate / freq;
    if (ratio > tsds_pkg::LIMIT_RATIO) begin
      start = ratio / 32'(tsds_pkg::LOW_FIXED);
      if (start > tsds_pkg::LIMIT_RATIO) start = tsds_pkg::LIMIT_RATIO;
      best_rem = '1;
      best_div = '0;
      // strict compare keeps the largest candidate on a tie
      for (logic [31:0] c = start; c > 32'(tsds_pkg::SEARCH_FLOOR); c--) begin
        rem = ratio % c;
        if (rem < {16'd0, best_rem}) begin
          best_rem = rem[15:0];
          best_div = c[15:0];
        end
      end
      if (best_div == 16'd0) return res;
      hi = {16'd0, best_div};
      lo = ratio / hi;
    end else begin
      lo = 32'(tsds_pkg::LOW_FIXED);
      hi = ratio / 32'(tsds_pkg::LOW_FIXED);
    end
    if (hi == 32'd0 || lo == 32'd0 || lo > 32'hFFFF || hi > 32'hFFFF) return res;
    res.hi_div = hi[15:0];
    res.lo_div = lo[15:0];
    res.err    = 1'b0;
    return res;
  endfunction

  // idle rates: sender 34 / receiver 55, then swapped, then none
  function automatic int send_idle_pct();
    int third;
    third = accepted * 3 / planned;
    return (third == 0) ? 34 : (third == 1) ? 55 : 0;
  endfunction

  function automatic int recv_idle_pct();
    int third;
    third = accepted * 3 / planned;
    return (third == 0) ? 55 : (third == 1) ? 34 : 0;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        split_queue.push_back(split_ratio(requested_freq, clock_shadow));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (freq_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          in_valid       <= 1'b1;
          requested_freq <= freq_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (split_queue.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want_split = split_queue.pop_front();
          in_flight--;
          if (high_divider !== want_split.hi_div) begin
            $error("high_divider: expected %0d, got %0d", want_split.hi_div, high_divider);
            errors++;
          end
          if (low_divider !== want_split.lo_div) begin
            $error("low_divider: expected %0d, got %0d", want_split.lo_div, low_divider);
            errors++;
          end
          if (status !== want_split.err) begin
            $error("status: expected %0d, got %0d", want_split.err, status);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic post(input logic [31:0] freq);
    in_flight++;
    freq_queue.push_back(freq);
  endtask

  task automatic settle();
    wait (in_flight == 0);
    @(posedge clk);
  endtask

  task automatic load_clock(input logic [31:0] rate);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we <= 1'b0;
    clock_shadow = rate;
  endtask

  // zero rates and ratios at or below the limit only; searches cost too many cycles to draw at random
  task automatic post_random(input int n);
    logic [31:0] freq;
    int          pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) freq = 32'd0;
      else if (pick <= 3) freq = $urandom;
      else freq = clock_shadow / $urandom_range(1, tsds_pkg::DIVIDER_LIMIT);
      if (freq != 32'd0 && clock_shadow / freq > tsds_pkg::LIMIT_RATIO)
        freq = clock_shadow / tsds_pkg::LIMIT_RATIO + 32'd1 + $urandom_range(0, 7);
      post(freq);
    end
  endtask

  initial begin
    planned = DIRECTED_COUNT + 5 * RAND_PER_CLOCK;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset clock: zero rate, ratio of 0, 1 and 2, a direct split, wide patterns
    post(32'd0);
    post(32'hFFFF_FFFF);
    post(32'd1193182);
    post(32'd596591);
    post(32'd19);
    post(32'h8000_0000);
    post(32'h5555_5555);

    // largest clock: full-range search with low divider overflow,
    // ratio exactly at the limit, and one above it (shortest search)
    load_clock(32'hFFFF_FFFF);
    post(32'd1);
    post(32'd66076);
    post(32'd66075);
    post(32'hFFFF_FFFF);

    // smallest clock
    load_clock(32'd1);
    post(32'd0);
    post(32'd1);
    post(32'd2);
    post(32'hFFFF_FFFF);

    load_clock(tsds_pkg::TIMER_CLOCK_RESET);
    post_random(RAND_PER_CLOCK);
    load_clock($urandom);
    post_random(RAND_PER_CLOCK);
    load_clock(32'hFFFF_FFFF);
    post_random(RAND_PER_CLOCK);
    load_clock(32'd1);
    post_random(RAND_PER_CLOCK);
    load_clock($urandom_range(2, 300000));
    post_random(RAND_PER_CLOCK);

    settle();
    repeat (64) @(posedge clk);
    if (errors == 0 && split_queue.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
